// ===== rtl/rcfbt_pkg.sv =====
package rcfbt_pkg;

   localparam int DATA_W  = 8;
   localparam int BLANK_W = 8;
   localparam int LEN_W   = 11;

   localparam int DEF_MAX_FIELD_LEN = 255;
   localparam int DEF_MAX_ROW_BYTES = 1024;

   // Depth of the queue between the classifier and the length accumulator.
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DATA_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [DATA_W-1:0] NUL_CHAR   = 8'h00;

   // One classified result on its way to the back end.
   typedef struct packed {
      logic [DATA_W-1:0]  out_byte;
      logic [BLANK_W-1:0] blanks_before;
      logic               row_end;
   } entry_type;

endpackage

// ===== rtl/rcfbt_req_if.sv =====
interface rcfbt_req_if;
   logic                       valid;
   logic                       ready;
   logic [rcfbt_pkg::DATA_W-1:0] data_byte;
   logic                       is_char_field;
   logic                       field_last;
   logic                       row_last;

   modport source (output valid, output data_byte, output is_char_field,
                   output field_last, output row_last, input ready);
   modport sink   (input valid, input data_byte, input is_char_field,
                   input field_last, input row_last, output ready);
endinterface

// ===== rtl/rcfbt_rsp_if.sv =====
interface rcfbt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rcfbt_pkg::DATA_W-1:0]  out_byte;
   logic [rcfbt_pkg::BLANK_W-1:0] blanks_before;
   logic                          row_end;
   logic [rcfbt_pkg::LEN_W-1:0]   row_length;

   modport source (output valid, output out_byte, output blanks_before,
                   output row_end, output row_length, input ready);
   modport sink   (input valid, input out_byte, input blanks_before,
                   input row_end, input row_length, output ready);
endinterface

// ===== rtl/record_char_field_blank_trimmer_top.sv =====
// A byte that yields a result is written into the queue as it transfers in, and from there
// it moves into the output register, which drives it onto rsp_chan until it transfers out.
// Bytes that only add to a held blank run yield nothing.
// Throughput: one byte per cycle while the queue has room, set by classifier and adder.
// Reset (synchronous, active high) empties the queue and output register, clears the
// blank count, zero flag and row length, and sets compress_enable to 1.
module record_char_field_blank_trimmer_top #(
   parameter int MAX_FIELD_LEN = rcfbt_pkg::DEF_MAX_FIELD_LEN,
   parameter int MAX_ROW_BYTES = rcfbt_pkg::DEF_MAX_ROW_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   rcfbt_req_if.sink   req_chan,
   rcfbt_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import rcfbt_pkg::*;

   // The front end classifies each byte as it is transferred in. It owns the
   // per-field state (held blank count and the zero-byte flag) and the enable
   // register, and it pushes an entry only for bytes that produce a result.
   // Its ready depends only on the queue having room.
   logic      push, pop, not_empty, full;
   entry_type push_entry, head_entry;

   rcfbt_front #(
      .MAX_FIELD_LEN (MAX_FIELD_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   // A short queue decouples the two halves, so a stalled result channel
   // does not stop input transfers until the queue fills.
   rcfbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (not_empty),
      .full       (full),
      .head_entry (head_entry)
   );

   // The back end keeps the running compressed row length, saturating it,
   // and holds each result in an output register. It pops a new entry
   // whenever that register is empty or being drained in the same cycle.
   rcfbt_back #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/rcfbt_front.sv =====
module rcfbt_front #(
   parameter int MAX_FIELD_LEN = rcfbt_pkg::DEF_MAX_FIELD_LEN
) (
   input  logic                 clock,
   input  logic                 reset,
   rcfbt_req_if.sink            req_chan,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic                 queue_full,
   output logic                 push,
   output rcfbt_pkg::entry_type push_entry
);
   import rcfbt_pkg::*;

   localparam logic [BLANK_W-1:0] MaxBlanks = BLANK_W'(MAX_FIELD_LEN);

   logic               compress_enable_ff;
   logic [BLANK_W-1:0] pending_blanks_ff, pending_blanks_in;
   logic               zero_seen_ff, zero_seen_in;
   logic               accept, is_char, row_last, field_end, emit;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign is_char        = req_chan.is_char_field && compress_enable_ff;
   assign row_last       = req_chan.row_last;
   assign field_end      = req_chan.field_last || row_last;

   always_comb begin
      emit              = 1'b0;
      push_entry        = '0;
      push_entry.row_end = row_last;
      pending_blanks_in = pending_blanks_ff;
      zero_seen_in      = zero_seen_ff;
      if (!is_char) begin
         emit                     = 1'b1;
         push_entry.out_byte      = req_chan.data_byte;
         push_entry.blanks_before = pending_blanks_ff;
         pending_blanks_in        = '0;
         zero_seen_in             = 1'b0;
      end else begin
         priority if (zero_seen_ff) begin
            emit = field_end;
         end else if (req_chan.data_byte == NUL_CHAR) begin
            zero_seen_in = 1'b1;
            emit         = field_end;
         end else if (req_chan.data_byte == BLANK_CHAR) begin
            if (pending_blanks_ff < MaxBlanks) begin
               pending_blanks_in = pending_blanks_ff + 1'b1;
            end
            emit = field_end;
         end else begin
            emit                     = 1'b1;
            push_entry.out_byte      = req_chan.data_byte;
            push_entry.blanks_before = pending_blanks_ff;
            pending_blanks_in        = '0;
         end
         // A field end with a zero, a blank or an earlier zero leaves a lone
         // terminator, which the defaults above already describe.
         if (field_end) begin
            pending_blanks_in = '0;
            zero_seen_in      = 1'b0;
         end
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         compress_enable_ff <= 1'b1;
         pending_blanks_ff  <= '0;
         zero_seen_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            compress_enable_ff <= csr_wdata;
         end
         if (accept) begin
            pending_blanks_ff <= pending_blanks_in;
            zero_seen_ff      <= zero_seen_in;
         end
      end
   end

endmodule

// ===== rtl/rcfbt_queue.sv =====
module rcfbt_queue #(
   parameter int DEPTH = rcfbt_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rcfbt_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 not_empty,
   output logic                 full,
   output rcfbt_pkg::entry_type head_entry
);
   import rcfbt_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   entry_type         slots_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      logic [PtrW-1:0] result;
      if (ptr == PtrW'(DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == CntW'(DEPTH));
   assign head_entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/rcfbt_back.sv =====
module rcfbt_back #(
   parameter int MAX_ROW_BYTES = rcfbt_pkg::DEF_MAX_ROW_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  rcfbt_pkg::entry_type head_entry,
   output logic                 pop,
   rcfbt_rsp_if.source          rsp_chan
);
   import rcfbt_pkg::*;

   localparam int CntW = $clog2(MAX_ROW_BYTES + 1);
   localparam int SumW = CntW + BLANK_W + 1;

   logic [CntW-1:0]    bytes_out_ff, bytes_out_in;
   logic [SumW-1:0]    sum, sat_sum;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  out_byte_ff;
   logic [BLANK_W-1:0] blanks_ff;
   logic               row_end_ff;
   logic [LEN_W-1:0]   row_length_ff, row_length_in;

   assign pop = not_empty && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      sum = SumW'(bytes_out_ff) + SumW'(head_entry.blanks_before) + SumW'(1);
      if (sum > SumW'(MAX_ROW_BYTES)) begin
         sat_sum = SumW'(MAX_ROW_BYTES);
      end else begin
         sat_sum = sum;
      end
      bytes_out_in  = head_entry.row_end ? '0 : CntW'(sat_sum);
      row_length_in = head_entry.row_end ? sat_sum[LEN_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_out_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            bytes_out_ff <= bytes_out_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_byte_ff   <= head_entry.out_byte;
         blanks_ff     <= head_entry.blanks_before;
         row_end_ff    <= head_entry.row_end;
         row_length_ff <= row_length_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_byte      = out_byte_ff;
   assign rsp_chan.blanks_before = blanks_ff;
   assign rsp_chan.row_end       = row_end_ff;
   assign rsp_chan.row_length    = row_length_ff;

endmodule

// ===== dv/tb_record_char_field_blank_trimmer_top.sv =====
module tb_record_char_field_blank_trimmer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rcfbt_pkg::*;

   // The clock runs at 100 MHz. Reset is held at the start of the run.
   localparam int CLK_PERIOD  = 10;
   localparam int RESET_TICKS = 8;

   // These must match the parameters that the block is built with. The instance below
   // keeps the package defaults.
   localparam int FIELD_CAP = DEF_MAX_FIELD_LEN;
   localparam int ROW_CAP   = DEF_MAX_ROW_BYTES;

   // A byte that only adds to a held blank run leaves nothing behind to wait for. So
   // before a register write we also wait SETTLE_CYCLES beyond the latency of the block.
   localparam int SETTLE_CYCLES = 8;

   // The long receiver hold-off is far longer than the internal queue, so the input
   // side must stall while it lasts.
   localparam int LONG_HOLD = 300;

   // The limit is far beyond what the whole run needs.
   localparam int RUN_LIMIT_NS = 3_000_000;

   // One input byte with its framing flags.
   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              is_char_field;
      logic              field_last;
      logic              row_last;
   } row_byte_type;

   // One compressed output byte as it shows up on the result channel.
   typedef struct packed {
      logic [DATA_W-1:0]  out_byte;
      logic [BLANK_W-1:0] blanks_before;
      logic               row_end;
      logic [LEN_W-1:0]   row_length;
   } trimmed_type;

   // A row of the directed table. When known is set, want is the result typed in by
   // hand. Otherwise the result comes from the predictor.
   typedef struct packed {
      row_byte_type stim;
      logic         known;
      trimmed_type  want;
   } dir_row_type;

   localparam trimmed_type NO_WANT = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic csr_wdata;

   rcfbt_req_if req_chan ();
   rcfbt_rsp_if rsp_chan ();

   record_char_field_blank_trimmer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // This is the state of the predictor. It mirrors the compress enable register, the
   // blank run held back in the current character field, the flag that a zero byte has
   // cut the field short, and the compressed length of the row so far.
   bit comp_en     = 1'b1;
   int held_blanks = 0;
   bit nul_hit     = 1'b0;
   int row_bytes   = 0;

   // Compressed bytes that have been predicted but have not yet come out, oldest first.
   trimmed_type awaited_bytes [$];

   int mismatch_cnt  = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // The main process bumps hold_seq to order one long hold-off. The receiver process
   // notices the change and counts the hold down on its own.
   int hold_seq  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // The directed table starts right after reset, with compression on. It covers the
   // extreme byte values, a blank run that is resolved by a later character, an
   // all-blank field, bytes that are ignored after a zero, a blank run carried by a
   // non-character byte, an empty field, a row that ends without its field end, and
   // rows of a single byte.
   dir_row_type dir_table [0:19] = '{
      '{'{8'hFF, 1'b0, 1'b1, 1'b0}, 1'b1, '{8'hFF, 8'd0, 1'b0, 11'd0}},
      '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b1, '{8'h00, 8'd0, 1'b0, 11'd0}},
      '{'{8'h41, 1'b1, 1'b0, 1'b0}, 1'b1, '{8'h41, 8'd0, 1'b0, 11'd0}},
      '{'{8'h20, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h20, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h42, 1'b1, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h20, 1'b1, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h7E, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h55, 1'b1, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h20, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h20, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h80, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{8'h00, 1'b1, 1'b1, 1'b0}, 1'b1, '{8'h00, 8'd0, 1'b0, 11'd0}},
      '{'{8'h20, 1'b1, 1'b0, 1'b1}, 1'b1, '{8'h00, 8'd0, 1'b1, 11'd13}},
      '{'{8'h7F, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'h7F, 8'd0, 1'b1, 11'd1}},
      '{'{8'h00, 1'b1, 1'b0, 1'b1}, 1'b1, '{8'h00, 8'd0, 1'b1, 11'd1}},
      '{'{8'h01, 1'b1, 1'b0, 1'b0}, 1'b1, '{8'h01, 8'd0, 1'b0, 11'd0}},
      '{'{8'h20, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{8'hFE, 1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT}
   };

   // This function works out what one accepted byte produces and updates the predictor
   // state. It returns 1 when the byte yields a compressed byte.
   function automatic bit compress_byte(input row_byte_type b, output trimmed_type r);
      bit as_char;
      bit ends_field;
      bit emits;
      int blanks;
      as_char    = b.is_char_field && comp_en;
      ends_field = b.field_last || b.row_last;
      emits      = 1'b0;
      blanks     = 0;
      r          = '0;
      if (!as_char) begin
         // A byte that is not compressed carries any blanks still held back.
         r.out_byte  = b.data_byte;
         blanks      = held_blanks;
         held_blanks = 0;
         nul_hit     = 1'b0;
         emits       = 1'b1;
      end else begin
         if (nul_hit) begin
            emits = ends_field;
         end else if (b.data_byte == NUL_CHAR) begin
            nul_hit = 1'b1;
            emits   = ends_field;
         end else if (b.data_byte == BLANK_CHAR) begin
            if (held_blanks < FIELD_CAP) held_blanks++;
            emits = ends_field;
         end else begin
            r.out_byte  = b.data_byte;
            blanks      = held_blanks;
            held_blanks = 0;
            emits       = 1'b1;
         end
         // At the end of a field, trailing blanks are dropped. A field that was trimmed
         // or cut short leaves the terminating zero that r already holds.
         if (ends_field) begin
            held_blanks = 0;
            nul_hit     = 1'b0;
         end
      end
      if (!emits) return 1'b0;
      row_bytes = row_bytes + blanks + 1;
      if (row_bytes > ROW_CAP) row_bytes = ROW_CAP;
      r.blanks_before = BLANK_W'(blanks);
      r.row_end       = b.row_last;
      r.row_length    = b.row_last ? LEN_W'(row_bytes) : '0;
      if (b.row_last) begin
         row_bytes   = 0;
         held_blanks = 0;
         nul_hit     = 1'b0;
      end
      return 1'b1;
   endfunction

   // This task offers one byte, after a random idle gap when the phase asks for one, and
   // holds it until the transfer happens. It then records the predicted result, or the
   // result typed into the table. Valid stays high when the next byte follows without a
   // gap, so it never gets two assignments in one time step.
   task automatic put_byte(input row_byte_type b, input bit known = 1'b0,
                           input trimmed_type want = '0);
      trimmed_type predicted;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= b.data_byte;
      req_chan.is_char_field <= b.is_char_field;
      req_chan.field_last    <= b.field_last;
      req_chan.row_last      <= b.row_last;
      do @(posedge clock); while (!req_chan.ready);
      if (compress_byte(b, predicted)) awaited_bytes.push_back(known ? want : predicted);
   endtask

   // This task stops offering bytes and waits until every predicted byte has come out.
   // It then waits SETTLE_CYCLES more, so that a byte which yields nothing is surely
   // through the block.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaited_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The random part mostly sends well-formed rows of mixed fields with random content.
   // Character fields are rich in blanks and zero bytes, so trimming, blank runs and
   // early termination all come up often. Some rows drop the final field end, and about
   // one item in eight is a byte with every field random.
   task automatic send_rows(input int n_items);
      int           sent;
      int           fields;
      int           len;
      int           pick;
      int           f;
      int           k;
      bit           as_char;
      bit           keep_fl;
      row_byte_type b;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 12) begin
            b.data_byte     = DATA_W'($urandom_range(255));
            b.is_char_field = 1'($urandom_range(1));
            b.field_last    = 1'($urandom_range(1));
            b.row_last      = 1'($urandom_range(1));
            put_byte(b);
            sent++;
         end else begin
            fields  = $urandom_range(5, 1);
            keep_fl = $urandom_range(99) >= 8;
            for (f = 0; f < fields; f++) begin
               as_char = $urandom_range(99) < 70;
               len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
               for (k = 0; k < len; k++) begin
                  pick = $urandom_range(99);
                  if (as_char && pick < 40) b.data_byte = BLANK_CHAR;
                  else if (as_char && pick < 46) b.data_byte = NUL_CHAR;
                  else b.data_byte = DATA_W'($urandom_range(255));
                  b.is_char_field = as_char;
                  b.row_last      = (f == fields - 1) && (k == len - 1);
                  b.field_last    = (k == len - 1) && (!b.row_last || keep_fl);
                  put_byte(b);
                  sent++;
               end
            end
         end
      end
   endtask

   // Each random phase starts from an idle block. It writes the compress enable
   // register, sets how often each side idles, and can order one long receiver
   // hold-off while the sender keeps offering bytes.
   task automatic run_phase(input bit compress_on, input int idle_pct, input int stall,
                            input bit long_hold, input int n_items);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= compress_on;
      @(posedge clock);
      csr_we        <= 1'b0;
      comp_en       = compress_on;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (long_hold) hold_seq++;
      send_rows(n_items);
   endtask

   // The receiver drives ready. It either stalls at random, at the rate that the phase
   // sets, or it counts down a long hold-off that the main process has ordered.
   always @(posedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Every transfer on the result channel is checked, field by field, against the oldest
   // predicted byte. A result that arrives when nothing is expected is a failure too.
   always @(posedge clock) begin : rsp_check
      trimmed_type got;
      trimmed_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.out_byte      = rsp_chan.out_byte;
         got.blanks_before = rsp_chan.blanks_before;
         got.row_end       = rsp_chan.row_end;
         got.row_length    = rsp_chan.row_length;
         if (awaited_bytes.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: result with none expected: byte %h blanks %0d end %b len %0d",
                        $time, got.out_byte, got.blanks_before, got.row_end,
                        got.row_length);
         end else begin
            want = awaited_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.blanks_before !== want.blanks_before ||
                got.row_end !== want.row_end || got.row_length !== want.row_length) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display({"%0t: expected byte %h blanks %0d end %b len %0d, ",
                            "got byte %h blanks %0d end %b len %0d"},
                           $time, want.out_byte, want.blanks_before, want.row_end,
                           want.row_length, got.out_byte, got.blanks_before, got.row_end,
                           got.row_length);
            end
         end
      end
   end

   initial begin
      int k;
      // Every input of the block is known from time zero on.
      req_chan.valid         = 1'b0;
      req_chan.data_byte     = '0;
      req_chan.is_char_field = 1'b0;
      req_chan.field_last    = 1'b0;
      req_chan.row_last      = 1'b0;
      rsp_chan.ready         = 1'b0;
      csr_we                 = 1'b0;
      csr_wdata              = 1'b0;
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed table runs with the register at its reset value and no idling.
      foreach (dir_table[i]) put_byte(dir_table[i].stim, dir_table[i].known, dir_table[i].want);

      // A blank run of 260 saturates the held count at the field limit, and the
      // character that resolves it carries the saturated count. A short all-blank field
      // then leaves a single zero, and the row ends on a non-character byte.
      for (k = 0; k < 260; k++) put_byte(row_byte_type'{BLANK_CHAR, 1'b1, 1'b0, 1'b0});
      put_byte(row_byte_type'{8'h5A, 1'b1, 1'b1, 1'b0}, 1'b1,
               trimmed_type'{8'h5A, 8'd255, 1'b0, 11'd0});
      for (k = 0; k < 5; k++) put_byte(row_byte_type'{BLANK_CHAR, 1'b1, k == 4, 1'b0});
      put_byte(row_byte_type'{8'hA5, 1'b0, 1'b1, 1'b1}, 1'b1,
               trimmed_type'{8'hA5, 8'd0, 1'b1, 11'd258});

      // The random phases. Each one drains first, so the sender also pauses until every
      // expected result has come. The first phase adds the long receiver hold-off on
      // top of running with no idling.
      run_phase(1'b1, 0, 0, 1'b1, 100);
      run_phase(1'b0, 59, 0, 1'b0, 100);
      run_phase(1'b1, 0, 59, 1'b0, 100);
      run_phase(1'b0, 18, 18, 1'b0, 100);
      run_phase(1'b1, 18, 18, 1'b0, 100);
      run_phase(1'b0, 0, 0, 1'b0, 100);

      wait_drained();
      if (mismatch_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // This is the safety net for a block that hangs: a stalled handshake or a result that
   // never arrives.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rcfbt_pkg.sv
rtl/rcfbt_req_if.sv
rtl/rcfbt_rsp_if.sv
rtl/rcfbt_front.sv
rtl/rcfbt_queue.sv
rtl/rcfbt_back.sv
rtl/record_char_field_blank_trimmer_top.sv
dv/tb_record_char_field_blank_trimmer_top.sv
